// ----- rtl/core/sprite_row_priority_compositor_unit_assert.svh -----
// Assertion helpers for the checker file.
`ifndef SPRITE_ROW_PRIORITY_COMPOSITOR_UNIT_ASSERT_SVH
`define SPRITE_ROW_PRIORITY_COMPOSITOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sprc_pkg.sv -----
`default_nettype none

package sprc_pkg;

  localparam int LINE_WIDTH_DEF = 512;
  localparam int ROW_PIX        = 16;   // pixels per sprite row and per line word
  localparam int PAL_ROWS       = 16;   // sprite palettes
  localparam int COLOUR_W       = 8;
  localparam int TAG_W          = 6;

  typedef enum logic [1:0] {
    OP_PAL_WRITE  = 2'd0,
    OP_MASK_BEGIN = 2'd1,
    OP_DRAW       = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [COLOUR_W-1:0] colour;
  } pix_t;

  typedef pix_t [ROW_PIX-1:0] word_t;
  typedef logic [ROW_PIX-1:0][COLOUR_W-1:0] pal_row_t;

endpackage

`default_nettype wire

// ----- rtl/core/sprc_ram.sv -----
`default_nettype none

module sprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/sprite_row_priority_compositor_unit.sv -----
`default_nettype none
// An item is captured on accept and then modified and written back in the busy
// state; a read-pixel result is registered to out_valid. The receiver cannot stall.
// A new item is taken only while busy is low, as the line memory is read then written.
// Reset: synchronous, active low; per-row valid bits make the line read as zero
// at once, so no clearing pass runs. The palette holds no reset value.

module sprite_row_priority_compositor_unit #(
  parameter int LINE_WIDTH = sprc_pkg::LINE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [10:0] in_x_pos,
  input  wire logic [15:0]        in_plane_zero,
  input  wire logic [15:0]        in_plane_one,
  input  wire logic [15:0]        in_plane_two,
  input  wire logic [15:0]        in_plane_three,
  input  wire logic [3:0]         in_palette_select,
  input  wire logic               in_mirror,
  input  wire logic               in_layer,
  input  wire logic [5:0]         in_sprite_rank,
  input  wire logic [8:0]         in_index,
  input  wire logic [7:0]         in_value,
  output logic                    out_valid,
  output logic [7:0]              out_pixel_colour,
  output logic [5:0]              out_pixel_tag
);
  import sprc_pkg::*;

  // Line memory: 16-pixel words split into an even-word bank and an odd-word
  // bank, so the two words a sprite row can touch are read together.
  localparam int WORDS      = (LINE_WIDTH + ROW_PIX - 1) / ROW_PIX;
  localparam int BANK_DEPTH = (WORDS + 1) / 2;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int VLD_N      = 2 ** AW;
  localparam int WIN        = 2 * ROW_PIX;
  localparam logic [11:0] LW12   = 12'(LINE_WIDTH);

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  logic accept;
  logic busy_r, busy_nxt;
  logic mask_used_r, mask_used_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_pixel_colour_r;
  logic [5:0] out_pixel_tag_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign out_valid        = out_valid_r;
  assign out_pixel_colour = out_pixel_colour_r;
  assign out_pixel_tag    = out_pixel_tag_r;

  // ---------------------------------------------------------------------
  // Read side (accept cycle): addresses come straight from the input ports
  // ---------------------------------------------------------------------
  op_t               in_op;
  logic signed [7:0] lo_w, hi_w, ev_w, od_w;
  logic [AW-1:0]     rd_addr_ev, rd_addr_od;
  logic [3:0]        pal_raddr;

  assign in_op = op_t'(in_opcode);
  assign lo_w  = 8'(in_x_pos >>> 4);
  assign hi_w  = lo_w + 8'sd1;
  assign ev_w  = lo_w[0] ? hi_w : lo_w;
  assign od_w  = lo_w[0] ? lo_w : hi_w;

  assign rd_addr_ev = (in_op == OP_READ) ? AW'(in_index >> 5) : ev_w[AW:1];
  assign rd_addr_od = (in_op == OP_READ) ? AW'(in_index >> 5) : od_w[AW:1];
  assign pal_raddr  = (in_op == OP_PAL_WRITE) ? in_index[7:4] : in_palette_select;

  // Captured item (payload, no reset)
  op_t               op_r;
  logic signed [10:0] x0_r;
  logic signed [7:0] lo_w_r;
  logic [15:0]       p0_r, p1_r, p2_r, p3_r;
  logic              mirror_r, layer_r;
  logic [5:0]        rank_r;
  logic [8:0]        index_r;
  logic [7:0]        value_r;
  logic              ve_r, vo_r;

  // Row valid bits; a row not yet written reads as all zero
  logic [VLD_N-1:0] vld_ev_r, vld_od_r;

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  word_t         ev_rdata, od_rdata, ev_wdata, od_wdata;
  logic          ev_we, od_we;
  logic [AW-1:0] ev_waddr, od_waddr;
  pal_row_t      pal_rdata, pal_wdata;
  logic          pal_we;

  sprc_ram #(.WIDTH($bits(word_t)), .DEPTH(BANK_DEPTH)) u_line_ev (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .raddr (rd_addr_ev),
    .rdata (ev_rdata)
  );

  sprc_ram #(.WIDTH($bits(word_t)), .DEPTH(BANK_DEPTH)) u_line_od (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .raddr (rd_addr_od),
    .rdata (od_rdata)
  );

  // Palette: one row per palette, written by read-modify-write
  sprc_ram #(.WIDTH($bits(pal_row_t)), .DEPTH(PAL_ROWS)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (index_r[7:4]),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // ---------------------------------------------------------------------
  // Modify side (busy state)
  // ---------------------------------------------------------------------
  word_t             ev_d, od_d, lo_d, hi_d;
  pix_t [WIN-1:0]    win_old, win_new;
  logic signed [7:0] hi_wm, ev_wm, od_wm;
  logic              ev_in, od_in;
  logic [3:0]        sub_x;
  logic signed [11:0] base_x;
  logic [5:0]        diff   [WIN];
  logic [3:0]        bsel   [WIN];
  logic [3:0]        nib    [WIN];
  logic signed [11:0] xp    [WIN];
  logic              drw    [WIN];
  pix_t              rd_pix;

  assign ev_d = ve_r ? ev_rdata : '0;
  assign od_d = vo_r ? od_rdata : '0;
  assign lo_d = lo_w_r[0] ? od_d : ev_d;
  assign hi_d = lo_w_r[0] ? ev_d : od_d;
  assign win_old = {hi_d, lo_d};

  assign hi_wm = lo_w_r + 8'sd1;
  assign ev_wm = lo_w_r[0] ? hi_wm : lo_w_r;
  assign od_wm = lo_w_r[0] ? lo_w_r : hi_wm;
  assign ev_in = ev_wm inside {[0:WORDS-1]};
  assign od_in = od_wm inside {[0:WORDS-1]};

  assign sub_x  = x0_r[3:0];
  assign base_x = $signed({x0_r[10], x0_r}) - $signed({8'b0, sub_x});

  // Window of 32 pixels over the two words; each slot finds its row pixel.
  always_comb begin
    win_new = win_old;
    for (int p = 0; p < WIN; p++) begin
      diff[p] = 6'(p) - {2'b0, sub_x};
      bsel[p] = mirror_r ? diff[p][3:0] : ~diff[p][3:0];
      nib[p]  = {p3_r[bsel[p]], p2_r[bsel[p]], p1_r[bsel[p]], p0_r[bsel[p]]};
      xp[p]   = base_x + 12'sd1 * $signed(12'(p));
      // in the row, opaque, and on the line
      drw[p]  = !diff[p][5] && !diff[p][4] && (nib[p] != 4'd0) &&
                (xp[p] inside {[0:LINE_WIDTH-1]});
      if (drw[p]) begin
        if (!layer_r) begin
          win_new[p].colour = pal_rdata[nib[p]];
          win_new[p].tag    = rank_r;
        end else if (!mask_used_r || (win_old[p].tag <= rank_r)) begin
          win_new[p].colour = pal_rdata[nib[p]];
        end
      end
    end
  end

  assign ev_wdata = lo_w_r[0] ? win_new[WIN-1:ROW_PIX] : win_new[ROW_PIX-1:0];
  assign od_wdata = lo_w_r[0] ? win_new[ROW_PIX-1:0] : win_new[WIN-1:ROW_PIX];
  assign ev_waddr = ev_wm[AW:1];
  assign od_waddr = od_wm[AW:1];
  assign ev_we    = busy_r && (op_r == OP_DRAW) && ev_in;
  assign od_we    = busy_r && (op_r == OP_DRAW) && od_in;

  always_comb begin
    pal_wdata = pal_rdata;
    pal_wdata[index_r[3:0]] = value_r;
  end
  assign pal_we = busy_r && (op_r == OP_PAL_WRITE) && index_r[8];

  // Pixel read: beyond the line answers zero
  always_comb begin
    rd_pix = index_r[4] ? od_d[index_r[3:0]] : ev_d[index_r[3:0]];
    if ({3'b0, index_r} >= LW12) begin
      rd_pix = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    busy_nxt      = accept;
    mask_used_nxt = mask_used_r;
    out_valid_nxt = 1'b0;
    if (busy_r) begin
      case (op_r)
        OP_MASK_BEGIN: mask_used_nxt = 1'b0;
        OP_DRAW:       if (!layer_r) mask_used_nxt = 1'b1;
        OP_READ:       out_valid_nxt = 1'b1;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      mask_used_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_ev_r    <= '0;
      vld_od_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      mask_used_r <= mask_used_nxt;
      out_valid_r <= out_valid_nxt;
      if (ev_we) vld_ev_r[ev_waddr] <= 1'b1;
      if (od_we) vld_od_r[od_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      x0_r     <= in_x_pos;
      lo_w_r   <= lo_w;
      p0_r     <= in_plane_zero;
      p1_r     <= in_plane_one;
      p2_r     <= in_plane_two;
      p3_r     <= in_plane_three;
      mirror_r <= in_mirror;
      layer_r  <= in_layer;
      rank_r   <= in_sprite_rank;
      index_r  <= in_index;
      value_r  <= in_value;
      ve_r     <= vld_ev_r[rd_addr_ev];
      vo_r     <= vld_od_r[rd_addr_od];
    end
    if (out_valid_nxt) begin
      out_pixel_colour_r <= rd_pix.colour;
      out_pixel_tag_r    <= rd_pix.tag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sprc_checker.sv -----
`default_nettype none
`include "sprite_row_priority_compositor_unit_assert.svh"

module sprc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_opcode,
  input wire logic       out_valid
);
  import sprc_pkg::*;

  `SPRC_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy missing after accept")
  `SPRC_ASSERT_NXT(a_busy_one_cycle, busy, !busy, "busy held too long")
  `SPRC_ASSERT_IMP(a_result_from_read, out_valid, $past(start && !busy && in_opcode == OP_READ, 2), "result without read item")
  `SPRC_ASSERT_IMP(a_read_answers, $past(rst_n, 2) && $past(rst_n) && $past(start && !busy && in_opcode == OP_READ, 2), out_valid, "read item gave no result")

endmodule

bind sprite_row_priority_compositor_unit sprc_checker u_sprc_checker (.*);

`default_nettype wire
